/* design/zcm_pkg.sv */
// ----------------------------------------------------------------------------
// zcm_pkg
// Shared types and codes of the zero-crossing marker: transaction payloads,
// request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package zcm_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;
    localparam int RowWidthBits  = 11;
    localparam int HeightBits    = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_ROW_WIDTH    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SLICE_HEIGHT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_POLARITY     = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    localparam logic POL_POSITIVE = 1'b0;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] sample;
    } t_zcm_in;

    typedef struct packed {
        logic mark;
        logic last_of_slice;
    } t_zcm_out;

endpackage

/* design/zero_crossing_marker.sv */
// ----------------------------------------------------------------------------
// zero_crossing_marker
// Streaming 4-neighbour zero-crossing marker over raster-order slices, with a
// two-row inside-bit line store and one-row-late mark output.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_zcm_in)
//  out      output     o_out_valid / i_out_stall o_out_data (t_zcm_out)
//  cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One transaction per cycle unless stalled; a mark appears the cycle after.
//  The line store has one write and one read port; a three-entry window of
//  registers supplies the left, center and right columns every cycle.
//  Reset is synchronous; no clearing pass, the store needs none.
//  Input stalls only while the output register is full and stalled.
// ----------------------------------------------------------------------------
module zero_crossing_marker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  zcm_pkg::t_zcm_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output zcm_pkg::t_zcm_out             o_out_data,
    input  logic                          i_cfg_we,
    input  logic [zcm_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [zcm_pkg::CfgDataWidth-1:0]  i_cfg_data
);
    import zcm_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = AW + 1;

    logic [RowWidthBits-1:0] r_row_width;
    logic [HeightBits-1:0]   r_slice_height;
    logic                    r_polarity;

    logic [AW-1:0]         r_column_count;
    logic [HeightBits-1:0] r_row_count;
    logic [AW-1:0]         r_flush_count;
    logic                  r_flush_pending;
    logic                  r_sel;

    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rd;
    logic       r_from_rd;
    logic [1:0] r_left;
    logic [1:0] r_cur;
    logic [1:0] r_right;
    logic [1:0] r_head0;
    logic [1:0] r_head1;

    logic     r_out_valid;
    t_zcm_out r_out_data;

    logic [WW-1:0]         eff_w;
    logic [HeightBits-1:0] eff_h;
    logic                  accept;
    logic                  is_flush;
    logic                  do_sample;
    logic                  do_flush;
    logic                  active;
    logic [AW-1:0]         x;
    logic [WW-1:0]         x_inc;
    logic                  end_of_row;
    logic                  pix_inside;
    logic [1:0]            right_val;
    logic                  prev_bit;
    logic                  nb_out;
    logic                  mark;
    logic [1:0]            wval;
    logic [AW-1:0]         rd_addr;
    logic [HeightBits:0]   rc_inc;
    logic                  produce;

    always_comb begin
        if (r_row_width == '0) begin
            eff_w = WW'(1);
        end else if (int'(r_row_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_row_width);
        end
        eff_h = (r_slice_height == '0) ? HeightBits'(1) : r_slice_height;
    end

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign is_flush   = (i_in_data.req_type == REQ_FLUSH);
    assign do_sample  = accept & ~is_flush & ~r_flush_pending;
    assign do_flush   = accept & is_flush & r_flush_pending;
    assign active     = do_sample | do_flush;

    assign x          = do_flush ? r_flush_count : r_column_count;
    assign x_inc      = {1'b0, x} + WW'(1);
    assign end_of_row = (x_inc >= eff_w);
    assign rd_addr    = AW'(x_inc + WW'(1));

    assign pix_inside = (r_polarity == POL_POSITIVE) ?
                        (~i_in_data.sample[15] & (i_in_data.sample != '0)) :
                        i_in_data.sample[15];

    assign right_val = r_from_rd ? r_rd : r_right;
    assign prev_bit  = r_cur[~r_sel];

    always_comb begin
        nb_out = 1'b0;
        if ((r_row_count >= HeightBits'(2)) && !r_cur[r_sel]) begin
            nb_out = 1'b1;
        end
        if ((x != '0) && !r_left[~r_sel]) begin
            nb_out = 1'b1;
        end
        if (!end_of_row && !right_val[~r_sel]) begin
            nb_out = 1'b1;
        end
        if (do_sample && !pix_inside) begin
            nb_out = 1'b1;
        end
        mark = prev_bit & nb_out;
    end

    assign wval    = r_sel ? {pix_inside, r_cur[0]} : {r_cur[1], pix_inside};
    assign rc_inc  = {1'b0, r_row_count} + (HeightBits+1)'(1);
    assign produce = do_flush | (do_sample & (r_row_count != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= RowWidthBits'(1024);
            r_slice_height <= HeightBits'(1024);
            r_polarity     <= POL_POSITIVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data[RowWidthBits-1:0];
                CFG_SLICE_HEIGHT: r_slice_height <= i_cfg_data[HeightBits-1:0];
                CFG_POLARITY:     r_polarity     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_sample) begin
            r_mem[x] <= wval;
        end
        if (active) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_sample && x == AW'(0)) begin
            r_head0 <= wval;
        end
        if (do_sample && x == AW'(1)) begin
            r_head1 <= wval;
        end
        if (active) begin
            r_left <= r_cur;
            if (do_sample && end_of_row) begin
                r_cur   <= (x == AW'(0)) ? wval : r_head0;
                r_right <= (x == AW'(1)) ? wval : r_head1;
            end else begin
                r_cur <= right_val;
            end
        end
        if (!o_in_stall) begin
            r_out_data.mark          <= mark;
            r_out_data.last_of_slice <= do_flush & end_of_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count  <= '0;
            r_row_count     <= '0;
            r_flush_count   <= '0;
            r_flush_pending <= 1'b0;
            r_sel           <= 1'b0;
            r_from_rd       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_out_valid <= produce;
            end
            if (active) begin
                r_from_rd <= ~(do_sample & end_of_row);
            end
            if (do_flush) begin
                if (end_of_row) begin
                    r_flush_pending <= 1'b0;
                    r_flush_count   <= '0;
                    r_row_count     <= '0;
                    r_column_count  <= '0;
                end else begin
                    r_flush_count <= AW'(x_inc);
                end
            end
            if (do_sample) begin
                if (end_of_row) begin
                    r_column_count <= '0;
                    r_sel          <= ~r_sel;
                    if (rc_inc >= {1'b0, eff_h}) begin
                        r_row_count     <= eff_h;
                        r_flush_pending <= 1'b1;
                        r_flush_count   <= '0;
                    end else begin
                        r_row_count <= rc_inc[HeightBits-1:0];
                    end
                end else begin
                    r_column_count <= AW'(x_inc);
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_flush_holds_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_pending |-> (r_column_count == '0))
        else $error("column count moved during flush");

    a_idle_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flush_pending |-> (r_flush_count == '0))
        else $error("flush count left nonzero outside flush");

    a_flush_gives_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_flush |=> o_out_valid)
        else $error("pending flush produced no mark");

    a_slice_end_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_flush && end_of_row) |=>
            (!r_flush_pending && r_row_count == '0 && o_out_data.last_of_slice))
        else $error("slice end did not rewind");

endmodule

/* sim/zero_crossing_marker_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zero_crossing_marker_test
// Self-checking bench for the zero-crossing marker. A queue-fed driver offers
// sample and flush transactions with random gaps. A monitor stalls the mark
// channel at random and compares every mark with a bench-side model of the
// two-row inside store. Registers change only while the block is idle: at
// slice boundaries, and in mid-slice for polarity, height and narrower rows.
// ----------------------------------------------------------------------------
module zero_crossing_marker_test;
    import zcm_pkg::*;

    localparam int          MAX_W        = 1024;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned HOLD_LENGTH  = 400;
    localparam logic        POL_NEGATIVE = ~POL_POSITIVE;
    localparam logic [9*16-1:0] GRID_3X3 = {16'hFFFF, 16'h7FFF, 16'h0000,
                                            16'h0001, 16'h0002, 16'h7FFF,
                                            16'h8000, 16'h0007, 16'h0001};

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    t_zcm_in                  i_in_data   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_zcm_out                 o_out_data;
    logic                     i_cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0]  i_cfg_data  = '0;

    logic        random_stall = 1'b0;
    int unsigned hold_cycles  = 0;
    bit          hold_done    = 1'b0;

    // register copies and line-store state of the marker
    logic [RowWidthBits-1:0] cfg_row_width    = 11'd1024;
    logic [HeightBits-1:0]   cfg_slice_height = 16'd1024;
    logic                    cfg_polarity     = POL_POSITIVE;
    logic [1:0]              inside_hist [MAX_W];
    int unsigned             col_idx     = 0;
    int unsigned             row_idx     = 0;
    int unsigned             flush_idx   = 0;
    bit                      flush_armed = 1'b0;
    logic                    older_bit   = 1'b0;

    t_zcm_in     pending_items [$];
    t_zcm_out    expected_marks [$];
    int unsigned inside_pct      = 50;
    int unsigned stim_items      = 0;
    int unsigned transactions_in = 0;
    int unsigned marks_seen      = 0;
    int unsigned mismatches      = 0;
    int unsigned cycles          = 0;
    int unsigned send_gap        = 0;
    int unsigned send_burst      = 0;
    int unsigned stall_left      = 0;
    int unsigned recv_burst      = 0;

    assign i_out_stall = random_stall | (hold_cycles != 0);

    zero_crossing_marker #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned width_in_use();
        if (cfg_row_width == 0) return 1;
        if (cfg_row_width > MAX_W) return MAX_W;
        return cfg_row_width;
    endfunction

    function automatic int unsigned height_in_use();
        return (cfg_slice_height == 0) ? 1 : cfg_slice_height;
    endfunction

    // down: 1 inside below, 0 outside below, -1 no row below
    function automatic logic pixel_mark(input int unsigned x, input int unsigned w,
                                        input int down);
        logic prev;
        logic found;
        prev  = ~older_bit;
        found = 1'b0;
        if (inside_hist[x][prev] == 1'b0) return 1'b0;
        if (row_idx >= 2 && inside_hist[x][older_bit] == 1'b0) found = 1'b1;
        if (x >= 1 && inside_hist[x-1][prev] == 1'b0) found = 1'b1;
        if (x + 1 < w && inside_hist[x+1][prev] == 1'b0) found = 1'b1;
        if (down == 0) found = 1'b1;
        return found;
    endfunction

    task automatic predict_marks(input t_zcm_in item);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        logic        is_in;
        t_zcm_out    res;
        w = width_in_use();
        h = height_in_use();
        if (item.req_type == REQ_FLUSH) begin
            if (flush_armed) begin
                x                 = flush_idx;
                res.mark          = pixel_mark(x, w, -1);
                res.last_of_slice = (x + 1 >= w);
                expected_marks.push_back(res);
                if (x + 1 >= w) begin
                    flush_armed = 1'b0;
                    flush_idx   = 0;
                    row_idx     = 0;
                    col_idx     = 0;
                end else begin
                    flush_idx = x + 1;
                end
            end
        end else if (!flush_armed) begin
            if (cfg_polarity == POL_POSITIVE)
                is_in = !item.sample[15] && item.sample != '0;
            else
                is_in = item.sample[15];
            x = (col_idx >= MAX_W) ? MAX_W - 1 : col_idx;
            if (row_idx >= 1) begin
                res.mark          = pixel_mark(x, w, is_in ? 1 : 0);
                res.last_of_slice = 1'b0;
                expected_marks.push_back(res);
            end
            inside_hist[x][older_bit] = is_in;
            if (x + 1 >= w) begin
                col_idx   = 0;
                older_bit = ~older_bit;
                row_idx   = (row_idx + 1) & 32'h1FFFF;
                if (row_idx >= h) begin
                    row_idx     = h;
                    flush_armed = 1'b1;
                    flush_idx   = 0;
                end
            end else begin
                col_idx = x + 1;
            end
        end
    endtask

    function automatic int unsigned idle_length(inout int unsigned burst);
        int unsigned r;
        if (burst != 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(50, 200);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_sample(input logic want_in);
        int unsigned r;
        logic [15:0] pos_v;
        logic [15:0] neg_v;
        r     = $urandom_range(0, 15);
        pos_v = (r == 0) ? 16'h0001 : (r == 1) ? 16'h7FFF : 16'($urandom_range(1, 32767));
        neg_v = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h8000
                                              : 16'h8000 | 16'($urandom_range(0, 32767));
        if (!want_in && r >= 13) return 16'h0000;
        return (want_in == (cfg_polarity == POL_POSITIVE)) ? pos_v : neg_v;
    endfunction

    task automatic queue_item(input logic req, input logic [15:0] value);
        t_zcm_in item;
        item.req_type = req;
        item.sample   = value;
        pending_items.push_back(item);
    endtask

    task automatic queue_samples(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 19) == 0) queue_item(REQ_FLUSH, 16'($urandom));
            queue_item(REQ_SAMPLE, pick_sample($urandom_range(1, 100) <= inside_pct));
            stim_items++;
        end
    endtask

    task automatic queue_flushes(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) queue_item(REQ_SAMPLE, 16'($urandom));
            queue_item(REQ_FLUSH, 16'($urandom));
            stim_items++;
        end
    endtask

    task automatic queue_slice();
        queue_samples(width_in_use() * height_in_use());
        queue_flushes(width_in_use());
    endtask

    task automatic queue_rest_of_slice();
        int unsigned w;
        int unsigned h;
        int unsigned samples_left;
        int unsigned rows_left;
        w = width_in_use();
        h = height_in_use();
        if (flush_armed) begin
            queue_flushes((flush_idx + 1 >= w) ? 1 : w - flush_idx);
        end else begin
            samples_left = (col_idx + 1 >= w) ? 1 : w - col_idx;
            rows_left    = (row_idx + 1 >= h) ? 0 : h - row_idx - 1;
            queue_samples(samples_left + rows_left * w);
            queue_flushes(w);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_marks.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CfgDataWidth-1:0];
        case (idx)
            CFG_ROW_WIDTH:    cfg_row_width    = value[RowWidthBits-1:0];
            CFG_SLICE_HEIGHT: cfg_slice_height = value[HeightBits-1:0];
            CFG_POLARITY:     cfg_polarity     = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_mark(input t_zcm_out got);
        t_zcm_out want;
        if (expected_marks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mark %0d with none expected: mark=%0b last_of_slice=%0b",
                         marks_seen, got.mark, got.last_of_slice);
        end else begin
            want = expected_marks.pop_front();
            if (got.mark !== want.mark || got.last_of_slice !== want.last_of_slice) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mark %0d: expected mark=%0b last_of_slice=%0b, got mark=%0b last_of_slice=%0b",
                             marks_seen, want.mark, want.last_of_slice,
                             got.mark, got.last_of_slice);
            end
        end
        marks_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_marks(i_in_data);
                transactions_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    i_in_data  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = idle_length(send_burst);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            random_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) check_mark(o_out_data);
            if (stall_left != 0) begin
                random_stall <= 1'b1;
                stall_left--;
            end else begin
                random_stall <= 1'b0;
                stall_left = idle_length(recv_burst);
            end
        end
    end

    // hold the mark channel once while plenty of transactions wait to go in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && transactions_in >= 20 && pending_items.size() > 10) begin
            hold_cycles <= HOLD_LENGTH;
            hold_done   <= 1'b1;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** zero_crossing_marker: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned first_random;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 slice: sign extremes, zero, an unmarked interior pixel
        write_reg(CFG_ROW_WIDTH, 3);
        write_reg(CFG_SLICE_HEIGHT, 3);
        write_reg(CFG_POLARITY, POL_POSITIVE);
        queue_item(REQ_FLUSH, 16'h1234);
        for (int i = 0; i < 9; i++) queue_item(REQ_SAMPLE, GRID_3X3[16*(8-i) +: 16]);
        queue_item(REQ_SAMPLE, 16'h0042);
        repeat (3) queue_item(REQ_FLUSH, 16'h0000);
        wait_idle();

        // zero width and height act as one pixel
        write_reg(CFG_ROW_WIDTH, 0);
        write_reg(CFG_SLICE_HEIGHT, 0);
        write_reg(CFG_POLARITY, POL_NEGATIVE);
        queue_item(REQ_SAMPLE, 16'hFFFB);
        queue_item(REQ_FLUSH, 16'hFFFF);
        queue_item(REQ_SAMPLE, 16'h0000);
        queue_item(REQ_FLUSH, 16'h0000);
        queue_item(REQ_SAMPLE, 16'h8000);
        queue_item(REQ_SAMPLE, 16'h0007);
        queue_item(REQ_FLUSH, 16'h0000);
        queue_item(REQ_FLUSH, 16'h0000);
        wait_idle();

        // widest rows cut short in mid-row, then the tallest slice cut short in mid-slice
        write_reg(CFG_ROW_WIDTH, 2047);
        write_reg(CFG_SLICE_HEIGHT, 2);
        queue_samples(40);
        wait_idle();
        write_reg(CFG_ROW_WIDTH, 24);
        queue_rest_of_slice();
        wait_idle();
        write_reg(CFG_ROW_WIDTH, 1);
        write_reg(CFG_SLICE_HEIGHT, 65535);
        write_reg(CFG_POLARITY, POL_POSITIVE);
        queue_samples(40);
        wait_idle();
        write_reg(CFG_SLICE_HEIGHT, 45);
        queue_rest_of_slice();
        wait_idle();

        first_random = stim_items;
        while (stim_items - first_random < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10)      w = 0;
            else if (r < 70) w = $urandom_range(1, 8);
            else if (r < 92) w = $urandom_range(9, 24);
            else             w = $urandom_range(25, 64);
            r = $urandom_range(0, 99);
            if (r < 8)       h = 0;
            else if (r < 80) h = $urandom_range(1, 6);
            else             h = $urandom_range(7, 16);
            write_reg(CFG_ROW_WIDTH, w);
            write_reg(CFG_SLICE_HEIGHT, h);
            write_reg(CFG_POLARITY, $urandom_range(0, 1) ? POL_NEGATIVE : POL_POSITIVE);
            inside_pct = $urandom_range(20, 95);
            repeat ($urandom_range(1, 3)) queue_slice();
            if ($urandom_range(0, 9) < 3) begin
                queue_samples($urandom_range(1, width_in_use() * height_in_use()));
                wait_idle();
                write_reg(CFG_POLARITY,
                          (cfg_polarity == POL_POSITIVE) ? POL_NEGATIVE : POL_POSITIVE);
                if ($urandom_range(0, 1)) write_reg(CFG_SLICE_HEIGHT, $urandom_range(0, 8));
                if ($urandom_range(0, 1))
                    write_reg(CFG_ROW_WIDTH, $urandom_range(0, width_in_use() - 1));
                queue_rest_of_slice();
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("** zero_crossing_marker: PASSED **");
        else
            $display("** zero_crossing_marker: FAILED **");
        $finish;
    end

endmodule
